// ===== hdl/adnp_pkg.sv =====
// shared widths, character codes and si prefix decode for the decimal number parser
`timescale 1ns / 1ps

package adnp_pkg;

    localparam int ACC_W              = 64;  // significand width
    localparam int CH_W               = 8;   // character width
    localparam int SI_W               = 6;   // width of an si prefix power
    localparam int MAX_SIG_DIGITS_DEF = 19;
    localparam int EXP_FIELD_BITS_DEF = 12;

    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2b;
    localparam logic [CH_W-1:0] CH_DOT   = 8'h2e;
    localparam logic [CH_W-1:0] CH_COMMA = 8'h2c;
    localparam logic [CH_W-1:0] CH_E_LO  = 8'h65;
    localparam logic [CH_W-1:0] CH_E_UP  = 8'h45;

    // power of ten of an si prefix letter, zero for anything else
    function automatic logic signed [SI_W-1:0] si_power(input logic [CH_W-1:0] c);
        logic signed [SI_W-1:0] p;
        begin
            case (c)
                8'h79:   p = -6'sd24; // y
                8'h7a:   p = -6'sd21; // z
                8'h61:   p = -6'sd18; // a
                8'h66:   p = -6'sd15; // f
                8'h70:   p = -6'sd12; // p
                8'h6e:   p = -6'sd9;  // n
                8'h75:   p = -6'sd6;  // u
                8'h6d:   p = -6'sd3;  // m
                8'h6b:   p = 6'sd3;   // k
                8'h4d:   p = 6'sd6;   // M
                8'h47:   p = 6'sd9;   // G
                8'h54:   p = 6'sd12;  // T
                8'h50:   p = 6'sd15;  // P
                8'h45:   p = 6'sd18;  // E
                8'h5a:   p = 6'sd21;  // Z
                8'h59:   p = 6'sd24;  // Y
                default: p = 6'sd0;
            endcase
            return p;
        end
    endfunction

endpackage

// ===== hdl/ascii_decimal_number_parser_core.sv =====
// top level of the streaming ascii decimal number parser
`timescale 1ns / 1ps

// Streaming ASCII decimal number parser. One character enters per transaction
// on the slave side and a NUL character ends the string; only the NUL
// transaction yields a result on the master side, through the output register. Text is an
// optional '-', integer digits, an optional '.' or ',' with fraction digits,
// then either a lone si prefix letter (y..Y, E is exa) as the last character or
// e/E followed by an optionally signed exponent; other trailing text is
// ignored. Unless a flag is set the result is (-1)^negative * significand * 10^exponent.
// Throughput is one character per clock: every character is folded into the
// parse state by one digit multiply-add (shift-and-add by ten) and a small
// decode between the input transaction and the state registers. The result
// sits in an output register backed by one skid register, so characters keep
// flowing while a finished result waits; the input stalls only when both hold
// a result. Master tdata from bit 0 up: negative, significand (64),
// decimal_exponent (EXP_FIELD_BITS, signed), digits_dropped,
// exponent_saturated, zero fill to whole bytes.
module ascii_decimal_number_parser_core #(
    parameter int MAX_SIG_DIGITS = adnp_pkg::MAX_SIG_DIGITS_DEF,
    parameter int EXP_FIELD_BITS = adnp_pkg::EXP_FIELD_BITS_DEF,
    localparam int RAW_W = 3 + adnp_pkg::ACC_W + EXP_FIELD_BITS,
    localparam int OUT_W = ((RAW_W + 7) / 8) * 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [adnp_pkg::CH_W-1:0] i_s_axis_tdata,  // ch
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // negative, significand, decimal_exponent, digits_dropped, exponent_saturated
    output logic [OUT_W-1:0]          o_m_axis_tdata
);

    localparam int ACC_W = adnp_pkg::ACC_W;
    localparam int CNT_W = $clog2(MAX_SIG_DIGITS + 1);
    localparam int SC_W  = EXP_FIELD_BITS + 2;   // running scale, +-2^E
    localparam int EV_W  = EXP_FIELD_BITS + 1;   // exponent digits, 0..2^E
    localparam int EM_W  = EXP_FIELD_BITS + 5;   // exponent digits times ten
    localparam int WK_W  = EXP_FIELD_BITS + 3;   // exponent sums before clamping
    localparam int LIM_I = 1 << EXP_FIELD_BITS;
    localparam int EMAX_I = (1 << (EXP_FIELD_BITS - 1)) - 1;
    localparam logic signed [WK_W-1:0] LIM  = WK_W'(LIM_I);
    localparam logic signed [WK_W-1:0] NLIM = -WK_W'(LIM_I);
    localparam logic signed [WK_W-1:0] EMAX = WK_W'(EMAX_I);
    localparam logic signed [WK_W-1:0] EMIN = -WK_W'(EMAX_I) - WK_W'(1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SIG_DIGITS);

    typedef enum logic [2:0] {
        PH_START,
        PH_INT,
        PH_FRAC,
        PH_SUFFIX,
        PH_EXPDIG,
        PH_IGNORE
    } t_phase;

    // parse state
    t_phase                     r_phase,   n_phase;
    logic                       r_sign,    n_sign;
    logic [ACC_W-1:0]           r_acc,     n_acc;
    logic [CNT_W-1:0]           r_cnt,     n_cnt;
    logic signed [SC_W-1:0]     r_scale,   n_scale;
    logic [adnp_pkg::CH_W-1:0]  r_pend,    n_pend;
    logic                       r_eneg,    n_eneg;
    logic [EV_W-1:0]            r_ev,      n_ev;
    logic                       r_dropped, n_dropped;

    // output register and skid register
    logic                       r_out_valid, r_skid_valid;
    logic [RAW_W-1:0]           r_out_data,  r_skid_data;

    logic                       s_accept;
    logic                       s_emit;
    logic [adnp_pkg::CH_W-1:0]  s_ch;
    logic [3:0]                 s_dig;
    logic                       s_is_dig;
    logic [ACC_W-1:0]           s_acc_mac;
    logic [EM_W-1:0]            s_ev_mac;
    logic [EV_W-1:0]            s_ev_next;
    logic signed [WK_W-1:0]     s_scale_w;
    logic signed [WK_W-1:0]     s_ev_s;
    logic signed [WK_W-1:0]     s_scale_up;
    logic signed [WK_W-1:0]     s_scale_dn;
    logic signed [WK_W-1:0]     s_scale_si;
    logic signed [WK_W-1:0]     s_scale_fold;
    logic signed [WK_W-1:0]     s_fin;
    logic signed [WK_W-1:0]     s_fin_clip;
    logic                       s_sat;
    logic [RAW_W-1:0]           s_result;

    function automatic logic signed [WK_W-1:0] clamp_lim(input logic signed [WK_W-1:0] v);
        logic signed [WK_W-1:0] r;
        begin
            if (v > LIM) begin
                r = LIM;
            end else if (v < NLIM) begin
                r = NLIM;
            end else begin
                r = v;
            end
            return r;
        end
    endfunction

    // input stalls only while the skid register is occupied
    assign o_s_axis_tready = !r_skid_valid;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign s_ch            = i_s_axis_tdata;
    assign s_emit          = s_accept && (s_ch == adnp_pkg::CH_NUL);

    // arithmetic shared by the phases
    assign s_is_dig  = (s_ch >= adnp_pkg::CH_ZERO) && (s_ch <= adnp_pkg::CH_NINE);
    assign s_dig     = s_ch[3:0];
    assign s_acc_mac = (r_acc << 3) + (r_acc << 1) + ACC_W'(s_dig);
    assign s_ev_mac  = (EM_W'(r_ev) << 3) + (EM_W'(r_ev) << 1) + EM_W'(s_dig);
    assign s_ev_next = (s_ev_mac > EM_W'(LIM_I)) ? EV_W'(LIM_I) : s_ev_mac[EV_W-1:0];
    assign s_scale_w = WK_W'(r_scale);
    assign s_ev_s    = signed'(WK_W'(r_ev));
    assign s_scale_up   = clamp_lim(s_scale_w + WK_W'(1));
    assign s_scale_dn   = clamp_lim(s_scale_w - WK_W'(1));
    assign s_scale_si   = clamp_lim(s_scale_w + WK_W'(adnp_pkg::si_power(r_pend)));
    assign s_scale_fold = clamp_lim(s_scale_w + (r_eneg ? -s_ev_s : s_ev_s));

    // final exponent for a NUL in the current phase, then clipped to the field
    always_comb begin
        case (r_phase)
            PH_SUFFIX: s_fin = s_scale_si;
            PH_EXPDIG: s_fin = s_scale_fold;
            default:   s_fin = s_scale_w;
        endcase
        s_sat = 1'b0;
        if (s_fin > EMAX) begin
            s_fin_clip = EMAX;
            s_sat      = 1'b1;
        end else if (s_fin < EMIN) begin
            s_fin_clip = EMIN;
            s_sat      = 1'b1;
        end else begin
            s_fin_clip = s_fin;
        end
    end

    assign s_result = {s_sat, r_dropped, s_fin_clip[EXP_FIELD_BITS-1:0], r_acc, r_sign};

    // next parse state for one accepted character
    always_comb begin
        n_phase   = r_phase;
        n_sign    = r_sign;
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        n_scale   = r_scale;
        n_pend    = r_pend;
        n_eneg    = r_eneg;
        n_ev      = r_ev;
        n_dropped = r_dropped;

        if (s_emit) begin
            // a finished string returns everything to its idle values
            n_phase   = PH_START;
            n_sign    = 1'b0;
            n_acc     = '0;
            n_cnt     = '0;
            n_scale   = '0;
            n_pend    = '0;
            n_eneg    = 1'b0;
            n_ev      = '0;
            n_dropped = 1'b0;
        end else if (s_accept) begin
            unique case (r_phase)
                PH_START, PH_INT, PH_FRAC: begin
                    if (r_phase == PH_START) begin
                        n_phase = PH_INT;
                    end
                    if ((r_phase == PH_START) && (s_ch == adnp_pkg::CH_MINUS)) begin
                        n_sign = 1'b1;
                    end else if (s_is_dig && (r_phase == PH_FRAC)) begin
                        // fraction digit: leading zeros only lower the exponent
                        if (r_cnt < CNT_MAX) begin
                            if (!((r_acc == '0) && (s_dig == 4'd0))) begin
                                n_acc = s_acc_mac;
                                n_cnt = r_cnt + CNT_W'(1);
                            end
                            n_scale = s_scale_dn[SC_W-1:0];
                        end else if (s_dig != 4'd0) begin
                            n_dropped = 1'b1;
                        end
                    end else if (s_is_dig) begin
                        // integer digit: excess digits raise the exponent
                        if (!((r_acc == '0) && (s_dig == 4'd0))) begin
                            if (r_cnt < CNT_MAX) begin
                                n_acc = s_acc_mac;
                                n_cnt = r_cnt + CNT_W'(1);
                            end else begin
                                n_scale = s_scale_up[SC_W-1:0];
                                if (s_dig != 4'd0) begin
                                    n_dropped = 1'b1;
                                end
                            end
                        end
                    end else if ((r_phase != PH_FRAC) &&
                                 ((s_ch == adnp_pkg::CH_DOT) || (s_ch == adnp_pkg::CH_COMMA))) begin
                        n_phase = PH_FRAC;
                    end else begin
                        n_pend  = s_ch;
                        n_phase = PH_SUFFIX;
                    end
                end
                PH_SUFFIX: begin
                    // more text after the suffix: only e/E opens an exponent
                    if ((r_pend == adnp_pkg::CH_E_LO) || (r_pend == adnp_pkg::CH_E_UP)) begin
                        n_phase = PH_EXPDIG;
                        if (s_ch == adnp_pkg::CH_MINUS) begin
                            n_eneg = 1'b1;
                        end else if (s_is_dig) begin
                            n_ev = s_ev_next;
                        end else if (s_ch != adnp_pkg::CH_PLUS) begin
                            n_phase = PH_IGNORE;
                        end
                    end else begin
                        n_phase = PH_IGNORE;
                    end
                end
                PH_EXPDIG: begin
                    if (s_is_dig) begin
                        n_ev = s_ev_next;
                    end else begin
                        n_scale = s_scale_fold[SC_W-1:0];
                        n_ev    = '0;
                        n_eneg  = 1'b0;
                        n_phase = PH_IGNORE;
                    end
                end
                default: begin
                    n_phase = PH_IGNORE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_START;
            r_sign    <= 1'b0;
            r_acc     <= '0;
            r_cnt     <= '0;
            r_scale   <= '0;
            r_pend    <= '0;
            r_eneg    <= 1'b0;
            r_ev      <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_sign    <= n_sign;
            r_acc     <= n_acc;
            r_cnt     <= n_cnt;
            r_scale   <= n_scale;
            r_pend    <= n_pend;
            r_eneg    <= n_eneg;
            r_ev      <= n_ev;
            r_dropped <= n_dropped;
        end
    end

    // output register with skid: a result landing on a stalled output waits in skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && !i_m_axis_tready) begin
            if (s_emit) begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid <= s_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_valid && !i_m_axis_tready) begin
            if (s_emit) begin
                r_skid_data <= s_result;
            end
        end else if (r_skid_valid) begin
            r_out_data <= r_skid_data;
        end else if (s_emit) begin
            r_out_data <= s_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'(r_out_data);

    // skid register is only ever filled behind a full output register
    a_skid_behind_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while the output register is empty");

    // a NUL character always restarts the parse
    a_nul_restarts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_emit |=> (r_phase == PH_START) && (r_acc == '0) && (r_scale == '0))
        else $error("parse state not cleared after end of string");

    // kept digit count never exceeds the limit
    a_cnt_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX)
        else $error("kept digit count beyond limit");

    // accumulator is zero exactly while no significant digit is kept
    a_acc_cnt : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) == (r_acc == '0))
        else $error("accumulator and digit count disagree");

endmodule

// ===== bench/tb.sv =====
// self-checking testbench for the streaming ascii decimal number parser
`timescale 1ns / 1ps

module tb;

    localparam int CH_W     = adnp_pkg::CH_W;
    localparam int ACC_W    = adnp_pkg::ACC_W;
    localparam int MAX_SIG  = adnp_pkg::MAX_SIG_DIGITS_DEF;
    localparam int EXP_BITS = adnp_pkg::EXP_FIELD_BITS_DEF;
    localparam int OUT_W    = ((3 + ACC_W + EXP_BITS + 7) / 8) * 8;
    localparam int EXP_LO   = 1 + ACC_W;
    localparam int DROP_BIT = EXP_LO + EXP_BITS;
    localparam int SAT_BIT  = DROP_BIT + 1;
    localparam int SCALE_LIM = 1 << EXP_BITS;
    localparam int EXP_HI_V  = (1 << (EXP_BITS - 1)) - 1;
    localparam int EXP_LO_V  = -(1 << (EXP_BITS - 1));
    localparam int RAND_ITEMS = 1325;
    localparam int CYCLE_LIMIT = 300000;
    localparam int TYPED_N = 7;
    localparam int DIR_N   = 24;

    typedef struct packed {
        logic                       negative;
        logic [ACC_W-1:0]           significand;
        logic signed [EXP_BITS-1:0] exponent;
        logic                       dropped;
        logic                       saturated;
    } t_num;

    typedef logic [CH_W-1:0] t_text[$];

    // parse position inside one string
    typedef enum logic [2:0] {
        S_LEAD, S_WHOLE, S_FRACT, S_TAIL, S_EXPON, S_SKIP
    } t_parse_pos;

    logic             i_clk    = 1'b0;
    logic             i_rst_n  = 1'b0;
    logic             s_valid  = 1'b0;
    logic [CH_W-1:0]  s_data   = '0;
    logic             s_ready;
    logic             m_valid;
    logic             m_ready  = 1'b0;
    logic [OUT_W-1:0] m_data;

    t_num results_due[$];
    int   err_count = 0;
    int   cycles    = 0;
    bit   send_burst = 1'b0;

    // parser image kept by the predictor
    t_parse_pos      tr_phase;
    bit              tr_neg;
    logic [ACC_W-1:0] tr_acc;
    int              tr_kept;
    int              tr_scale;
    logic [CH_W-1:0] tr_tail;
    bit              tr_eneg;
    int              tr_eval;
    bit              tr_lost;

    ascii_decimal_number_parser_core #(
        .MAX_SIG_DIGITS (MAX_SIG),
        .EXP_FIELD_BITS (EXP_BITS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic void clear_parse();
        tr_phase = S_LEAD;
        tr_neg   = 1'b0;
        tr_acc   = '0;
        tr_kept  = 0;
        tr_scale = 0;
        tr_tail  = '0;
        tr_eneg  = 1'b0;
        tr_eval  = 0;
        tr_lost  = 1'b0;
    endfunction

    function automatic bit is_digit(input logic [CH_W-1:0] c);
        return c >= adnp_pkg::CH_ZERO && c <= adnp_pkg::CH_NINE;
    endfunction

    // running scale is held within plus or minus 2^EXP_BITS
    function automatic int clip_scale(input int v);
        if (v > SCALE_LIM) return SCALE_LIM;
        if (v < -SCALE_LIM) return -SCALE_LIM;
        return v;
    endfunction

    function automatic void add_exp_digit(input logic [CH_W-1:0] c);
        int v;
        v = tr_eval * 10 + int'(c - adnp_pkg::CH_ZERO);
        tr_eval = (v > SCALE_LIM) ? SCALE_LIM : v;
    endfunction

    function automatic void apply_exponent();
        tr_scale = clip_scale(tr_scale + (tr_eneg ? -tr_eval : tr_eval));
        tr_eval  = 0;
        tr_eneg  = 1'b0;
    endfunction

    // digits, decimal point or the first character past the number
    function automatic void take_number_char(input logic [CH_W-1:0] c);
        logic [ACC_W-1:0] d;
        d = ACC_W'(c - adnp_pkg::CH_ZERO);
        if (is_digit(c)) begin
            if (tr_phase == S_FRACT) begin
                if (tr_kept < MAX_SIG) begin
                    // leading fraction zeros only move the exponent
                    if (!(tr_acc == 0 && d == 0)) begin
                        tr_acc  = tr_acc * 64'd10 + d;
                        tr_kept = tr_kept + 1;
                    end
                    tr_scale = clip_scale(tr_scale - 1);
                end else if (d != 0) begin
                    tr_lost = 1'b1;
                end
            end else if (!(tr_acc == 0 && d == 0)) begin
                if (tr_kept < MAX_SIG) begin
                    tr_acc  = tr_acc * 64'd10 + d;
                    tr_kept = tr_kept + 1;
                end else begin
                    // integer digit past the kept count still counts a decade
                    tr_scale = clip_scale(tr_scale + 1);
                    if (d != 0) tr_lost = 1'b1;
                end
            end
        end else if (tr_phase == S_WHOLE &&
                     (c == adnp_pkg::CH_DOT || c == adnp_pkg::CH_COMMA)) begin
            tr_phase = S_FRACT;
        end else begin
            tr_tail  = c;
            tr_phase = S_TAIL;
        end
    endfunction

    // advances the parser image by one character, returns 1 with the result on nul
    function automatic bit parse_char(input logic [CH_W-1:0] c, output t_num r);
        bit fire;
        int e;
        int si;
        fire = 1'b0;
        r    = '0;
        case (tr_phase)
            S_LEAD: begin
                if (c == adnp_pkg::CH_NUL) begin
                    fire = 1'b1;
                end else begin
                    tr_phase = S_WHOLE;
                    if (c == adnp_pkg::CH_MINUS) tr_neg = 1'b1;
                    else take_number_char(c);
                end
            end
            S_WHOLE, S_FRACT: begin
                if (c == adnp_pkg::CH_NUL) fire = 1'b1;
                else take_number_char(c);
            end
            S_TAIL: begin
                if (c == adnp_pkg::CH_NUL) begin
                    // last character: si prefix scaling
                    case (tr_tail)
                        "y":     si = -24;
                        "z":     si = -21;
                        "a":     si = -18;
                        "f":     si = -15;
                        "p":     si = -12;
                        "n":     si = -9;
                        "u":     si = -6;
                        "m":     si = -3;
                        "k":     si = 3;
                        "M":     si = 6;
                        "G":     si = 9;
                        "T":     si = 12;
                        "P":     si = 15;
                        "E":     si = 18;
                        "Z":     si = 21;
                        "Y":     si = 24;
                        default: si = 0;
                    endcase
                    tr_scale = clip_scale(tr_scale + si);
                    fire = 1'b1;
                end else if (tr_tail == adnp_pkg::CH_E_LO || tr_tail == adnp_pkg::CH_E_UP) begin
                    tr_phase = S_EXPON;
                    if (c == adnp_pkg::CH_MINUS) tr_eneg = 1'b1;
                    else if (is_digit(c)) add_exp_digit(c);
                    else if (c != adnp_pkg::CH_PLUS) tr_phase = S_SKIP;
                end else begin
                    tr_phase = S_SKIP;
                end
            end
            S_EXPON: begin
                if (c == adnp_pkg::CH_NUL) begin
                    apply_exponent();
                    fire = 1'b1;
                end else if (is_digit(c)) begin
                    add_exp_digit(c);
                end else begin
                    apply_exponent();
                    tr_phase = S_SKIP;
                end
            end
            default: begin
                if (c == adnp_pkg::CH_NUL) fire = 1'b1;
            end
        endcase
        if (fire) begin
            e = tr_scale;
            if (e > EXP_HI_V) begin
                e = EXP_HI_V;
                r.saturated = 1'b1;
            end
            if (e < EXP_LO_V) begin
                e = EXP_LO_V;
                r.saturated = 1'b1;
            end
            r.negative    = tr_neg;
            r.significand = tr_acc;
            r.exponent    = EXP_BITS'(e);
            r.dropped     = tr_lost;
            clear_parse();
        end
        return fire;
    endfunction

    function automatic logic [CH_W-1:0] rand_digit();
        // zeros come often so that leading zero runs show up
        if ($urandom_range(0, 3) == 0) return adnp_pkg::CH_ZERO;
        return adnp_pkg::CH_ZERO + CH_W'($urandom_range(0, 9));
    endfunction

    // one character transaction after a random gap; the predictor follows on acceptance
    task automatic feed_char(input logic [CH_W-1:0] c, input bit use_typed, input t_num typed);
        int gap;
        t_num r;
        gap = send_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        do @(posedge i_clk); while (!s_ready);
        if (parse_char(c, r)) results_due.push_back(use_typed ? typed : r);
    endtask

    // whole string followed by the terminating nul
    task automatic feed_text(input t_text t, input bit use_typed, input t_num typed);
        send_burst = ($urandom_range(0, 3) == 0);
        foreach (t[k]) feed_char(t[k], 1'b0, '0);
        feed_char(adnp_pkg::CH_NUL, use_typed, typed);
    endtask

    // hold the sender until every result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [ACC_W-1:0] want,
                               input logic [ACC_W-1:0] got);
        if (want !== got) begin
            err_count++;
            if (err_count <= 10)
                $display("%s differs: expected %0h, got %0h", name, want, got);
        end
    endtask

    // directed strings; the first TYPED_N rows carry their result typed in
    string dir_text [DIR_N] = '{
        "",
        "-",
        "9999999999999999999",
        "1e99999",
        "-1e-99999",
        "1Y",
        "1y",
        "007",
        "0.0050",
        "12345678901234567890123",
        "100000000000000000000000",
        "1.23456789012345678901234",
        "0.000000000000000000000000000001",
        "5-",
        "5+",
        "5x",
        "1e+x",
        "1e-",
        "-2,5e+3",
        "3.5k volts",
        "42E",
        "7e12abc",
        ".5\377",
        "1.2.3"
    };

    t_num dir_want [TYPED_N] = '{
        '{1'b0, 64'd0, 12'sd0, 1'b0, 1'b0},
        '{1'b1, 64'd0, 12'sd0, 1'b0, 1'b0},
        '{1'b0, 64'd9999999999999999999, 12'sd0, 1'b0, 1'b0},
        '{1'b0, 64'd1, 12'sd2047, 1'b0, 1'b1},
        '{1'b1, 64'd1, 12'h800, 1'b0, 1'b1},
        '{1'b0, 64'd1, 12'sd24, 1'b0, 1'b0},
        '{1'b0, 64'd1, -12'sd24, 1'b0, 1'b0}
    };

    // result side: random stalls, every accepted transaction checked in order
    initial begin
        int stall;
        t_num want;
        t_num got;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!m_valid);
            got.negative    = m_data[0];
            got.significand = m_data[ACC_W:1];
            got.exponent    = m_data[EXP_LO +: EXP_BITS];
            got.dropped     = m_data[DROP_BIT];
            got.saturated   = m_data[SAT_BIT];
            if (results_due.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result transaction: %0h", m_data);
            end else begin
                want = results_due.pop_front();
                check_field("negative", ACC_W'(want.negative), ACC_W'(got.negative));
                check_field("significand", want.significand, got.significand);
                check_field("decimal_exponent", ACC_W'(want.exponent), ACC_W'(got.exponent));
                check_field("digits_dropped", ACC_W'(want.dropped), ACC_W'(got.dropped));
                check_field("exponent_saturated", ACC_W'(want.saturated),
                            ACC_W'(got.saturated));
            end
        end
    end

    // character side
    initial begin
        t_text t;
        int    texts;
        int    rand_items;
        int    nint;
        int    nfrac;
        int    nexp;
        int    suffix;
        string si_set;
        si_set = "yzafpnumkMGTPEZY";
        clear_parse();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++) begin
            t.delete();
            for (int k = 0; k < dir_text[i].len(); k++) t.push_back(dir_text[i][k]);
            if (i < TYPED_N) feed_text(t, 1'b1, dir_want[i]);
            else feed_text(t, 1'b0, '0);
        end
        drain_results();

        texts      = 0;
        rand_items = 0;
        while (rand_items < RAND_ITEMS) begin
            t.delete();
            if ($urandom_range(0, 9) < 8) begin
                // well-formed number with random content
                if ($urandom_range(0, 2) == 0) t.push_back(adnp_pkg::CH_MINUS);
                nint = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 26)
                                                   : $urandom_range(0, 6);
                repeat (nint) t.push_back(rand_digit());
                if ($urandom_range(0, 1) == 1) begin
                    t.push_back($urandom_range(0, 1) ? adnp_pkg::CH_DOT : adnp_pkg::CH_COMMA);
                    nfrac = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 26)
                                                        : $urandom_range(0, 6);
                    repeat (nfrac) t.push_back(rand_digit());
                end
                suffix = $urandom_range(0, 4);
                if (suffix == 1) t.push_back(si_set[$urandom_range(0, 15)]);
                if (suffix == 2 || suffix == 3) begin
                    t.push_back($urandom_range(0, 1) ? adnp_pkg::CH_E_LO : adnp_pkg::CH_E_UP);
                    case ($urandom_range(0, 2))
                        1: t.push_back(adnp_pkg::CH_PLUS);
                        2: t.push_back(adnp_pkg::CH_MINUS);
                        default: ;
                    endcase
                    // long exponent runs push the scale into saturation
                    nexp = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 12)
                                                       : $urandom_range(0, 3);
                    repeat (nexp) t.push_back(rand_digit());
                end
                if (suffix >= 3) begin
                    repeat ($urandom_range(1, 4)) t.push_back(CH_W'($urandom_range(1, 255)));
                end
            end else begin
                // noise and broken text
                repeat ($urandom_range(0, 8)) t.push_back(CH_W'($urandom_range(1, 255)));
            end
            feed_text(t, 1'b0, '0);
            rand_items += t.size() + 1;
            texts++;
            if (texts % 40 == 0) drain_results();
        end

        drain_results();
        repeat (16) @(posedge i_clk);
        err_count += results_due.size();
        if (err_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
